// ===== rtl/core/ap2lb_pkg.sv =====
`default_nettype none

package ap2lb_pkg;

  // Field geometry of the pixel word on the ports
  localparam int unsigned FIELD_W = 64;
  localparam int unsigned FIELDS  = 4;
  localparam int unsigned WORD_W  = FIELD_W * FIELDS;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_SIDE_DEF = 48;
  localparam int unsigned PLANES_DEF   = 72;
  localparam int unsigned LANES_DEF    = 32;

  // Config port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        REG_POOL_LEVEL = 1'b0;  // register index (paddr[2])

  // Pyramid levels
  localparam logic [1:0] LEVEL_OFF     = 2'd0;
  localparam logic [1:0] LEVEL_FULL    = 2'd1;
  localparam logic [1:0] LEVEL_HALF    = 2'd2;
  localparam logic [1:0] LEVEL_QUARTER = 2'd3;

  // Per-word control handed from the position tracker to the pooling stage
  typedef struct packed {
    logic wr_en;    // even row: word goes into the line store
    logic odd_row;  // odd row: word enters the pooling stage
    logic odd_col;
    logic last;     // final window of the run
  } pos_tag_t;

  // floor((a+b+c+d)/4) of four signed bytes, truncated to 8 bits
  function automatic logic [7:0] lane_avg(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c, input logic [7:0] d);
    logic [9:0] s;
    s = {{2{a[7]}}, a} + {{2{b[7]}}, b} + {{2{c[7]}}, c} + {{2{d[7]}}, d};
    return s[9:2];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ap2lb_line_mem.sv =====
`default_nettype none

module ap2lb_line_mem #(
  parameter int unsigned DEPTH = ap2lb_pkg::MAX_SIDE_DEF,
  parameter int unsigned DW    = 8 * ap2lb_pkg::LANES_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [DW-1:0] wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== rtl/core/ap2lb_ctrl.sv =====
`default_nettype none

module ap2lb_ctrl #(
  parameter int unsigned MAX_SIDE = ap2lb_pkg::MAX_SIDE_DEF,
  parameter int unsigned PLANES   = ap2lb_pkg::PLANES_DEF,
  localparam int unsigned AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [1:0]          pool_level_i,
  input  wire logic                accept_i,
  output ap2lb_pkg::pos_tag_t      tag_o,
  output logic [AW-1:0]            col_o
);

  localparam int unsigned SW = $clog2(MAX_SIDE + 1);
  localparam int unsigned PW = (PLANES > 1) ? $clog2(PLANES) : 1;
  localparam logic [PW:0] PLANES_W = (PW + 1)'(PLANES);

  logic [SW-1:0] side;
  logic [SW-1:0] col_q, col_d, row_q, row_d, col_eff, row_eff, col_inc, row_inc;
  logic [PW-1:0] plane_q, plane_d, plane_eff;
  logic [PW:0]   plane_inc;
  logic          active;

  always_comb begin
    case (pool_level_i)
      ap2lb_pkg::LEVEL_FULL:    side = SW'(MAX_SIDE);
      ap2lb_pkg::LEVEL_HALF:    side = SW'(MAX_SIDE / 2);
      ap2lb_pkg::LEVEL_QUARTER: side = SW'(MAX_SIDE / 4);
      default:                  side = '0;
    endcase
  end

  assign active = (side != '0);

  // counters left out of range by a level change restart at zero
  assign col_eff   = (col_q >= side) ? '0 : col_q;
  assign row_eff   = (row_q >= side) ? '0 : row_q;
  assign plane_eff = ({1'b0, plane_q} >= PLANES_W) ? '0 : plane_q;

  assign col_inc   = col_eff + SW'(1);
  assign row_inc   = row_eff + SW'(1);
  assign plane_inc = {1'b0, plane_eff} + (PW + 1)'(1);

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    plane_d = plane_q;
    if (accept_i && active) begin
      col_d   = col_eff;
      row_d   = row_eff;
      plane_d = plane_eff;
      if (col_inc == side) begin
        col_d = '0;
        if (row_inc == side) begin
          row_d   = '0;
          plane_d = (plane_inc == PLANES_W) ? '0 : plane_inc[PW-1:0];
        end else begin
          row_d = row_inc;
        end
      end else begin
        col_d = col_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      plane_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      plane_q <= plane_d;
    end
  end

  always_comb begin
    tag_o.wr_en   = active && !row_eff[0];
    tag_o.odd_row = active && row_eff[0];
    tag_o.odd_col = col_eff[0];
    tag_o.last    = ({1'b0, plane_eff} == PLANES_W - (PW + 1)'(1)) &&
                    ({1'b0, row_eff} + (SW + 1)'(2) >= {1'b0, side}) &&
                    ({1'b0, col_eff} + (SW + 1)'(2) >= {1'b0, side});
  end

  assign col_o = col_eff[AW-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/ap2lb_pool.sv =====
`default_nettype none

module ap2lb_pool #(
  parameter int unsigned LANES = ap2lb_pkg::LANES_DEF,
  localparam int unsigned DW   = 8 * LANES
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire ap2lb_pkg::pos_tag_t  tag_i,
  input  wire logic [DW-1:0]        pix_i,
  input  wire logic [DW-1:0]        upper_i,   // line store word, valid from the cycle after the read
  output logic                      ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [DW-1:0]             win_avg_o,
  output logic                      out_last_o
);

  logic                s1_valid_q, s1_valid_d, s1_adv;
  ap2lb_pkg::pos_tag_t s1_tag_q;
  logic [DW-1:0]       s1_pix_q;
  logic [DW-1:0]       ul_q, held_q;      // upper-left and lower-left of the window
  logic                out_valid_q, out_valid_d, out_free;
  logic [DW-1:0]       win_avg_q, avg;
  logic                out_last_q;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && (!s1_tag_q.odd_col || out_free);
  assign ready_o    = !s1_valid_q || s1_adv;
  assign s1_valid_d = (accept_i && tag_i.odd_row) ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      avg[8*k +: 8] = ap2lb_pkg::lane_avg(ul_q[8*k +: 8], upper_i[8*k +: 8],
                                          held_q[8*k +: 8], s1_pix_q[8*k +: 8]);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv && s1_tag_q.odd_col) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && tag_i.odd_row) begin
      s1_tag_q <= tag_i;
      s1_pix_q <= pix_i;
    end
    if (s1_adv && !s1_tag_q.odd_col) begin
      ul_q   <= upper_i;
      held_q <= s1_pix_q;
    end
    if (s1_adv && s1_tag_q.odd_col) begin
      win_avg_q  <= avg;
      out_last_q <= s1_tag_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign win_avg_o   = win_avg_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/avg_pool_2x2_line_buffered.sv =====
`default_nettype none

// 2x2 stride-2 average pooling over square planes streamed in raster order, one
// pixel word (LANES signed bytes) per cycle while in_ready_o is high; PLANES planes
// make a run. The side is MAX_SIDE, MAX_SIDE/2 or MAX_SIDE/4 for pool_level 1, 2
// or 3 (level 0 swallows input). Even rows go into a one-port-write, one-port-read
// line store of MAX_SIDE words; odd rows read it back, so sustained throughput is
// one word per cycle while the output is not stalled. A window result passes two
// register stages, the s1 stage and a one-word output register that holds it;
// last_of_run_o flags the final window of the run. Lanes at or above LANES read as
// zero. pool_level must be written only while idle; the block does not enforce it.
module avg_pool_2x2_line_buffered #(
  parameter int unsigned MAX_SIDE = ap2lb_pkg::MAX_SIDE_DEF,
  parameter int unsigned PLANES   = ap2lb_pkg::PLANES_DEF,
  parameter int unsigned LANES    = ap2lb_pkg::LANES_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // config port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [ap2lb_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [ap2lb_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [ap2lb_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                     pready,
  // pixel input
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [ap2lb_pkg::FIELD_W-1:0]       lanes_0_to_7_i,
  input  wire logic [ap2lb_pkg::FIELD_W-1:0]       lanes_8_to_15_i,
  input  wire logic [ap2lb_pkg::FIELD_W-1:0]       lanes_16_to_23_i,
  input  wire logic [ap2lb_pkg::FIELD_W-1:0]       lanes_24_to_31_i,
  // window output
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic      [ap2lb_pkg::FIELD_W-1:0]       avg_0_to_7_o,
  output logic      [ap2lb_pkg::FIELD_W-1:0]       avg_8_to_15_o,
  output logic      [ap2lb_pkg::FIELD_W-1:0]       avg_16_to_23_o,
  output logic      [ap2lb_pkg::FIELD_W-1:0]       avg_24_to_31_o,
  output logic                                     last_of_run_o
);

  localparam int unsigned DW = 8 * LANES;
  localparam int unsigned AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

  logic [1:0]                    pool_level_q;
  logic                          cfg_wr, accept;
  ap2lb_pkg::pos_tag_t           tag;
  logic [AW-1:0]                 col;
  logic [ap2lb_pkg::WORD_W-1:0]  in_word, out_word;
  logic [DW-1:0]                 pix, upper, win_avg;

  // config register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == ap2lb_pkg::REG_POOL_LEVEL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_level_q <= ap2lb_pkg::LEVEL_FULL;
    end else if (cfg_wr) begin
      pool_level_q <= pwdata[1:0];
    end
  end

  assign prdata = (paddr[2] == ap2lb_pkg::REG_POOL_LEVEL) ?
                  ap2lb_pkg::CFG_DATA_W'(pool_level_q) : '0;

  assign accept  = in_valid_i && in_ready_o;
  assign in_word = {lanes_24_to_31_i, lanes_16_to_23_i, lanes_8_to_15_i, lanes_0_to_7_i};
  assign pix     = in_word[DW-1:0];

  ap2lb_ctrl #(
    .MAX_SIDE (MAX_SIDE),
    .PLANES   (PLANES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pool_level_i (pool_level_q),
    .accept_i     (accept),
    .tag_o        (tag),
    .col_o        (col)
  );

  ap2lb_line_mem #(
    .DEPTH (MAX_SIDE),
    .DW    (DW)
  ) u_line_mem (
    .clk_i     (clk_i),
    .wr_en_i   (accept && tag.wr_en),
    .wr_addr_i (col),
    .wr_data_i (pix),
    .rd_en_i   (accept && tag.odd_row),
    .rd_addr_i (col),
    .rd_data_o (upper)
  );

  ap2lb_pool #(
    .LANES (LANES)
  ) u_pool (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .tag_i       (tag),
    .pix_i       (pix),
    .upper_i     (upper),
    .ready_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .win_avg_o   (win_avg),
    .out_last_o  (last_of_run_o)
  );

  assign out_word       = ap2lb_pkg::WORD_W'(win_avg);
  assign avg_0_to_7_o   = out_word[0*ap2lb_pkg::FIELD_W +: ap2lb_pkg::FIELD_W];
  assign avg_8_to_15_o  = out_word[1*ap2lb_pkg::FIELD_W +: ap2lb_pkg::FIELD_W];
  assign avg_16_to_23_o = out_word[2*ap2lb_pkg::FIELD_W +: ap2lb_pkg::FIELD_W];
  assign avg_24_to_31_o = out_word[3*ap2lb_pkg::FIELD_W +: ap2lb_pkg::FIELD_W];

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int unsigned WORD_W     = ap2lb_pkg::WORD_W;
  localparam int unsigned FIELD_W    = ap2lb_pkg::FIELD_W;
  localparam int unsigned FIELDS     = ap2lb_pkg::FIELDS;
  localparam int unsigned CFG_ADDR_W = ap2lb_pkg::CFG_ADDR_W;
  localparam int unsigned CFG_DATA_W = ap2lb_pkg::CFG_DATA_W;
  localparam int unsigned SIDE_FULL  = ap2lb_pkg::MAX_SIDE_DEF;
  localparam int unsigned RUN_PLANES = ap2lb_pkg::PLANES_DEF;
  localparam int unsigned BYTES      = WORD_W / 8;
  localparam int unsigned GAP_MAX    = 13;
  localparam logic [7:0]  BYTE_CORNERS [4] = '{8'h80, 8'h7F, 8'h00, 8'hFF};

  typedef struct packed {
    logic [WORD_W-1:0] avg;
    logic              last;
  } window_t;

  // One directed pixel: every lane holds fill, or the word is random.
  typedef struct {
    logic [7:0] fill;
    bit         rnd;
    bit         typed;
    logic [7:0] avg_fill;
  } pattern_row_t;

  // Two rows of a 12-wide plane; windows cover the byte extremes and floor rounding.
  pattern_row_t corner_rows [24] = '{
    '{8'h80, 0, 0, 8'h00}, '{8'h80, 0, 0, 8'h00}, '{8'h7F, 0, 0, 8'h00},
    '{8'h7F, 0, 0, 8'h00}, '{8'hFF, 0, 0, 8'h00}, '{8'hFF, 0, 0, 8'h00},
    '{8'h00, 0, 0, 8'h00}, '{8'h00, 0, 0, 8'h00}, '{8'h7F, 0, 0, 8'h00},
    '{8'h7F, 0, 0, 8'h00}, '{8'h00, 1, 0, 8'h00}, '{8'h00, 1, 0, 8'h00},
    '{8'h80, 0, 0, 8'h00}, '{8'h80, 0, 1, 8'h80}, '{8'h7F, 0, 0, 8'h00},
    '{8'h7F, 0, 1, 8'h7F}, '{8'hFF, 0, 0, 8'h00}, '{8'hFF, 0, 1, 8'hFF},
    '{8'h00, 0, 0, 8'h00}, '{8'hFF, 0, 1, 8'hFF}, '{8'h7F, 0, 0, 8'h00},
    '{8'h80, 0, 1, 8'h3F}, '{8'h00, 1, 0, 8'h00}, '{8'h00, 1, 0, 8'h00}
  };

  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [FIELD_W-1:0]    lanes_0_to_7_i   = '0;
  logic [FIELD_W-1:0]    lanes_8_to_15_i  = '0;
  logic [FIELD_W-1:0]    lanes_16_to_23_i = '0;
  logic [FIELD_W-1:0]    lanes_24_to_31_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b1;
  logic [FIELD_W-1:0]    avg_0_to_7_o;
  logic [FIELD_W-1:0]    avg_8_to_15_o;
  logic [FIELD_W-1:0]    avg_16_to_23_o;
  logic [FIELD_W-1:0]    avg_24_to_31_o;
  logic                  last_of_run_o;

  // pooling shadow state
  logic [WORD_W-1:0] line_store [SIDE_FULL];
  logic [WORD_W-1:0] left_pixel;
  int unsigned       col_pos   = 0;
  int unsigned       row_pos   = 0;
  int unsigned       plane_pos = 0;
  logic [1:0]        level_now = ap2lb_pkg::LEVEL_FULL;

  window_t     windows_due [$];
  int unsigned errors      = 0;
  int unsigned words_sent  = 0;
  int unsigned words_taken = 0;
  int unsigned sink_wait   = 0;
  bit          src_calm    = 1'b0;
  bit          sink_calm   = 1'b0;

  avg_pool_2x2_line_buffered uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .lanes_0_to_7_i   (lanes_0_to_7_i),
    .lanes_8_to_15_i  (lanes_8_to_15_i),
    .lanes_16_to_23_i (lanes_16_to_23_i),
    .lanes_24_to_31_i (lanes_24_to_31_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .avg_0_to_7_o     (avg_0_to_7_o),
    .avg_8_to_15_o    (avg_8_to_15_o),
    .avg_16_to_23_o   (avg_16_to_23_o),
    .avg_24_to_31_o   (avg_24_to_31_o),
    .last_of_run_o    (last_of_run_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned side_for(input logic [1:0] lvl);
    case (lvl)
      ap2lb_pkg::LEVEL_FULL:    return SIDE_FULL;
      ap2lb_pkg::LEVEL_HALF:    return SIDE_FULL / 2;
      ap2lb_pkg::LEVEL_QUARTER: return SIDE_FULL / 4;
      default:                  return 0;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] average_window(input logic [WORD_W-1:0] a,
                                                       input logic [WORD_W-1:0] b,
                                                       input logic [WORD_W-1:0] c,
                                                       input logic [WORD_W-1:0] d);
    logic [WORD_W-1:0] r;
    int                s;
    for (int k = 0; k < BYTES; k++) begin
      s = $signed(a[8*k +: 8]) + $signed(b[8*k +: 8]) + $signed(c[8*k +: 8]) +
          $signed(d[8*k +: 8]);
      r[8*k +: 8] = 8'(s >>> 2);  // arithmetic shift gives the floor
    end
    return r;
  endfunction

  // Advances the shadow pooler by one accepted word; returns 1 when a window closes.
  function automatic bit step_pooler(input logic [WORD_W-1:0] pix, output window_t w);
    int unsigned side;
    bit          produced;
    side = side_for(level_now);
    produced = 1'b0;
    w = '0;
    if (side == 0) return 1'b0;
    // a level change can leave the counters past the new side
    if (col_pos >= side) col_pos = 0;
    if (row_pos >= side) row_pos = 0;
    if (plane_pos >= RUN_PLANES) plane_pos = 0;
    if (row_pos % 2 == 0) begin
      line_store[col_pos] = pix;
    end else if (col_pos % 2 == 0) begin
      left_pixel = pix;
    end else begin
      w.avg = average_window(line_store[col_pos-1], line_store[col_pos], left_pixel, pix);
      w.last = plane_pos == RUN_PLANES - 1 && row_pos + 2 >= side && col_pos + 2 >= side;
      produced = 1'b1;
    end
    col_pos++;
    if (col_pos >= side) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= side) begin
        row_pos = 0;
        plane_pos++;
        if (plane_pos >= RUN_PLANES) plane_pos = 0;
      end
    end
    return produced;
  endfunction

  function automatic logic [WORD_W-1:0] random_pixel();
    logic [WORD_W-1:0] p;
    for (int f = 0; f < WORD_W / 32; f++) p[32*f +: 32] = $urandom;
    case ($urandom_range(0, 7))
      0: p = {BYTES{8'h80}};
      1: p = {BYTES{8'h7F}};
      2: for (int k = 0; k < BYTES; k++) p[8*k +: 8] = BYTE_CORNERS[$urandom_range(0, 3)];
      default: ;
    endcase
    return p;
  endfunction

  // Holds valid across back-to-back words; drops it only when a gap is drawn.
  task automatic send_word(input logic [WORD_W-1:0] pix);
    int unsigned gap;
    gap = src_calm ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {lanes_24_to_31_i, lanes_16_to_23_i, lanes_8_to_15_i, lanes_0_to_7_i} <= pix;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_sent++;
    if (words_sent % 64 == 0) src_calm = $urandom_range(0, 3) == 0;
  endtask

  task automatic feed_pixel();
    logic [WORD_W-1:0] pix;
    window_t           w;
    pix = random_pixel();
    send_word(pix);
    if (step_pooler(pix, w)) begin
      windows_due.push_back(w);
    end
  endtask

  // Config writes happen only with nothing in flight.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (windows_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_level(input logic [1:0] lvl);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ap2lb_pkg::REG_POOL_LEVEL, 2'b00};
    pwdata  <= CFG_DATA_W'(lvl);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    level_now = lvl;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata[1:0] !== lvl) begin
      $display("%0t: pool_level read back expected %0d got %0d", $time, lvl, prdata[1:0]);
      errors++;
    end
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    window_t     want;
    window_t     got;
    int unsigned stall;
    if (out_valid_o && out_ready_i) begin
      got.avg  = {avg_24_to_31_o, avg_16_to_23_o, avg_8_to_15_o, avg_0_to_7_o};
      got.last = last_of_run_o;
      if (windows_due.size() == 0) begin
        $display("%0t: window word with none expected, got %h last %b", $time, got.avg,
                 got.last);
        errors++;
      end else begin
        want = windows_due.pop_front();
        for (int f = 0; f < FIELDS; f++) begin
          if (got.avg[f*FIELD_W +: FIELD_W] !== want.avg[f*FIELD_W +: FIELD_W]) begin
            $display("%0t: avg_%0d_to_%0d expected %h got %h", $time, 8 * f, 8 * f + 7,
                     want.avg[f*FIELD_W +: FIELD_W], got.avg[f*FIELD_W +: FIELD_W]);
            errors++;
          end
        end
        if (got.last !== want.last) begin
          $display("%0t: last_of_run expected %b got %b", $time, want.last, got.last);
          errors++;
        end
      end
      words_taken++;
      if (words_taken % 32 == 0) sink_calm = $urandom_range(0, 3) == 0;
      stall = sink_calm ? 0 : $urandom_range(0, GAP_MAX);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        sink_wait   <= stall;
      end
    end else if (sink_wait != 0) begin
      sink_wait <= sink_wait - 1;
      if (sink_wait == 1) out_ready_i <= 1'b1;
    end
  end

  initial begin
    pattern_row_t      row;
    logic [WORD_W-1:0] pix;
    window_t           w;
    bit                produced;
    int unsigned       drain;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_level(ap2lb_pkg::LEVEL_QUARTER);
    foreach (corner_rows[i]) begin
      row = corner_rows[i];
      pix = row.rnd ? random_pixel() : {BYTES{row.fill}};
      send_word(pix);
      produced = step_pooler(pix, w);
      if (row.typed) begin
        w.avg  = {BYTES{row.avg_fill}};
        w.last = 1'b0;
        windows_due.push_back(w);
      end else if (produced) begin
        windows_due.push_back(w);
      end
    end

    // A full-width even row fills every line store entry, so later level
    // changes in mid-plane never read an entry that was never written.
    settle();
    set_level(ap2lb_pkg::LEVEL_FULL);
    repeat (150) feed_pixel();
    settle();
    set_level(ap2lb_pkg::LEVEL_OFF);
    repeat (40) feed_pixel();
    repeat (10) begin
      settle();
      set_level(2'($urandom_range(0, 3)));
      repeat ($urandom_range(60, 220)) feed_pixel();
    end

    // Smallest planes to close out the stream.
    settle();
    set_level(ap2lb_pkg::LEVEL_QUARTER);
    repeat (200) feed_pixel();
    in_valid_i <= 1'b0;

    drain = 0;
    while (windows_due.size() != 0 && drain < 5000) begin
      @(posedge clk_i);
      drain++;
    end
    if (windows_due.size() != 0) begin
      $display("%0t: %0d window words never came out", $time, windows_due.size());
      errors++;
    end
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
